/* sv/psu_pkg.sv */
package psu_pkg;

   localparam int MAX_ROW_PIXELS_DEF      = 4096;
   localparam int MAX_BYTES_PER_PIXEL_DEF = 4;

   localparam int BYTE_W      = 8;
   localparam int ROW_WIDTH_W = 13;
   localparam int BPP_W       = 3;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_IDX_W   = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_WIDTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BPP       = 1'd1;

   localparam int MIN_BPP = 3;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } psu_filter_type;

   typedef struct packed {
      psu_filter_type    filter;
      logic [BYTE_W-1:0] a;
      logic [BYTE_W-1:0] b;
      logic [BYTE_W-1:0] c;
   } psu_pred_in_type;

   // unknown filter codes decode as none
   function automatic psu_filter_type psu_decode_filter(input logic [BYTE_W-1:0] code);
      psu_filter_type f;
      if (code > BYTE_W'(FILT_PAETH)) begin
         f = FILT_NONE;
      end else begin
         f = psu_filter_type'(code[2:0]);
      end
      return f;
   endfunction

endpackage

/* sv/psu_if.sv */
interface psu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   logic       image_start;

   modport source (output valid, output stream_byte, output image_start, input ready);
   modport sink   (input valid, input stream_byte, input image_start, output ready);
endinterface

interface psu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_byte;
   logic       end_of_pixel;
   logic       end_of_row;

   modport source (output valid, output pixel_byte, output end_of_pixel, output end_of_row,
                   input ready);
   modport sink   (input valid, input pixel_byte, input end_of_pixel, input end_of_row,
                   output ready);
endinterface

/* sv/psu_line_buf.sv */
module psu_line_buf
   import psu_pkg::*;
#(
   parameter int DEPTH = MAX_ROW_PIXELS_DEF * MAX_BYTES_PER_PIXEL_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/psu_predictor.sv */
module psu_predictor
   import psu_pkg::*;
(
   input  psu_pred_in_type   pred_in,
   output logic [BYTE_W-1:0] pred
);

   logic signed [BYTE_W+1:0] a_s;
   logic signed [BYTE_W+1:0] b_s;
   logic signed [BYTE_W+1:0] c_s;
   logic signed [BYTE_W+1:0] da;
   logic signed [BYTE_W+1:0] db;
   logic signed [BYTE_W+1:0] dc;
   logic        [BYTE_W+1:0] pa;
   logic        [BYTE_W+1:0] pb;
   logic        [BYTE_W+1:0] pc;
   logic        [BYTE_W:0]   avg_sum;
   logic        [BYTE_W-1:0] paeth;

   always_comb begin
      a_s = signed'({2'b00, pred_in.a});
      b_s = signed'({2'b00, pred_in.b});
      c_s = signed'({2'b00, pred_in.c});
      da  = b_s - c_s;
      db  = a_s - c_s;
      dc  = a_s + b_s - c_s - c_s;
      pa  = (da < 0) ? unsigned'(-da) : unsigned'(da);
      pb  = (db < 0) ? unsigned'(-db) : unsigned'(db);
      pc  = (dc < 0) ? unsigned'(-dc) : unsigned'(dc);
      priority if (pa <= pb && pa <= pc) begin
         paeth = pred_in.a;
      end else if (pb <= pc) begin
         paeth = pred_in.b;
      end else begin
         paeth = pred_in.c;
      end
      avg_sum = {1'b0, pred_in.a} + {1'b0, pred_in.b};
   end

   always_comb begin
      unique case (pred_in.filter)
         FILT_SUB:   pred = pred_in.a;
         FILT_UP:    pred = pred_in.b;
         FILT_AVG:   pred = avg_sum[BYTE_W:1];
         FILT_PAETH: pred = paeth;
         default:    pred = '0;
      endcase
   end

endmodule

/* sv/png_scanline_unfilter_unit.sv */
// a pixel byte passes through the reconstruct stage register and then the output register
// throughput: one item per cycle while the output is not stalled; a filter-type byte is consumed and produces no result
// line buffer is a one-port-write, one-port-read ram with registered read
// reset (synchronous, active high) restarts at row zero awaiting a filter byte and
// loads width 1 and 3 bytes per pixel; line buffer is not cleared and first row ignores what it reads
module png_scanline_unfilter_unit
   import psu_pkg::*;
#(
   parameter int MAX_ROW_PIXELS      = MAX_ROW_PIXELS_DEF,
   parameter int MAX_BYTES_PER_PIXEL = MAX_BYTES_PER_PIXEL_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   psu_req_if.sink               req_if,
   psu_rsp_if.source             rsp_if,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ROW_DEPTH = MAX_ROW_PIXELS * MAX_BYTES_PER_PIXEL;
   localparam int AW        = $clog2(ROW_DEPTH);
   localparam int RB_W      = $clog2(ROW_DEPTH + 1);
   localparam int PIX_W     = $clog2(MAX_ROW_PIXELS + 1);
   localparam int BPPV_W    = $clog2(MAX_BYTES_PER_PIXEL + 1);
   localparam int SLOT_W    = $clog2(MAX_BYTES_PER_PIXEL);

   // configuration, stored clamped
   logic [PIX_W-1:0]  width_ff,     width_in;
   logic [BPPV_W-1:0] bpp_ff,       bpp_in;
   logic [RB_W-1:0]   row_bytes_ff, row_bytes_in;

   // front sequencer state
   logic              awaiting_ff,  awaiting_in;
   logic              first_row_ff, first_row_in;
   psu_filter_type    filter_ff,    filter_in;
   logic [AW-1:0]     pos_ff,       pos_in;
   logic [1:0]        mod3_ff,      mod3_in;

   // reconstruct stage
   logic              s1_valid_ff,  s1_valid_in;
   logic [BYTE_W-1:0] s1_sb_ff;
   psu_filter_type    s1_filter_ff;
   logic [AW-1:0]     s1_pos_ff;
   logic [SLOT_W-1:0] s1_slot_ff;
   logic              s1_past_ff;
   logic              s1_first_ff;
   logic              s1_eop_ff;
   logic              s1_eor_ff;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_eop_ff;
   logic              rsp_eor_ff;

   logic              accept;
   logic              await_eff;
   logic              first_eff;
   logic              accept_pix;
   logic              s1_go;
   logic              s1_fire;
   logic [SLOT_W-1:0] slot;
   logic              past;
   logic [BPPV_W-1:0] slot_nxt;
   logic              slot_last;
   logic              eor;

   logic [BYTE_W-1:0] left_ff [MAX_BYTES_PER_PIXEL];
   logic [BYTE_W-1:0] upl_ff  [MAX_BYTES_PER_PIXEL];
   logic [BYTE_W-1:0] above;
   psu_pred_in_type   pred_in;
   logic [BYTE_W-1:0] pred;
   logic [BYTE_W-1:0] val;

   // ---------------- configuration ----------------
   always_comb begin
      width_in     = width_ff;
      bpp_in       = bpp_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ROW_WIDTH: begin
               if (csr_wdata == '0) begin
                  width_in = PIX_W'(1);
               end else if (32'(csr_wdata) > 32'(MAX_ROW_PIXELS)) begin
                  width_in = PIX_W'(MAX_ROW_PIXELS);
               end else begin
                  width_in = PIX_W'(csr_wdata);
               end
            end
            CSR_BPP: begin
               if (csr_wdata[BPP_W-1:0] < BPP_W'(MIN_BPP)) begin
                  bpp_in = BPPV_W'(MIN_BPP);
               end else if (32'(csr_wdata[BPP_W-1:0]) > 32'(MAX_BYTES_PER_PIXEL)) begin
                  bpp_in = BPPV_W'(MAX_BYTES_PER_PIXEL);
               end else begin
                  bpp_in = BPPV_W'(csr_wdata[BPP_W-1:0]);
               end
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end
      // row length follows the new geometry in the same cycle it is written
      row_bytes_in = RB_W'(RB_W'(width_in) * RB_W'(bpp_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= PIX_W'(1);
         bpp_ff       <= BPPV_W'(MIN_BPP);
         row_bytes_ff <= RB_W'(MIN_BPP);
      end else begin
         width_ff     <= width_in;
         bpp_ff       <= bpp_in;
         row_bytes_ff <= row_bytes_in;
      end
   end

   // ---------------- handshake ----------------
   assign s1_go        = !rsp_valid_ff || rsp_if.ready;
   assign s1_fire      = s1_valid_ff && s1_go;
   assign req_if.ready = !s1_valid_ff || s1_go;
   assign accept       = req_if.valid && req_if.ready;

   // ---------------- front sequencer ----------------
   always_comb begin
      await_eff  = req_if.image_start || awaiting_ff;
      first_eff  = req_if.image_start || first_row_ff;
      accept_pix = accept && !await_eff;
      // byte slot in the pixel from the current pixel size: mod 3 counter or low bits
      slot       = (bpp_ff == BPPV_W'(MIN_BPP)) ? SLOT_W'(mod3_ff) : SLOT_W'(pos_ff[1:0]);
      past       = pos_ff >= AW'(bpp_ff);
      slot_nxt   = BPPV_W'(slot) + BPPV_W'(1);
      slot_last  = slot_nxt == bpp_ff;
      eor        = (RB_W'(pos_ff) + RB_W'(1)) >= row_bytes_ff;

      awaiting_in  = awaiting_ff;
      first_row_in = first_row_ff;
      filter_in    = filter_ff;
      pos_in       = pos_ff;
      mod3_in      = mod3_ff;
      if (accept) begin
         if (await_eff) begin
            filter_in    = psu_decode_filter(req_if.stream_byte);
            awaiting_in  = 1'b0;
            first_row_in = first_eff;
            pos_in       = '0;
            mod3_in      = '0;
         end else if (eor) begin
            awaiting_in  = 1'b1;
            first_row_in = 1'b0;
            pos_in       = '0;
            mod3_in      = '0;
         end else if (pos_ff == AW'(ROW_DEPTH - 1)) begin
            pos_in  = '0;
            mod3_in = '0;
         end else begin
            pos_in  = pos_ff + AW'(1);
            mod3_in = (mod3_ff == 2'd2) ? 2'd0 : mod3_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff  <= 1'b1;
         first_row_ff <= 1'b1;
         filter_ff    <= FILT_NONE;
         pos_ff       <= '0;
         mod3_ff      <= '0;
      end else begin
         awaiting_ff  <= awaiting_in;
         first_row_ff <= first_row_in;
         filter_ff    <= filter_in;
         pos_ff       <= pos_in;
         mod3_ff      <= mod3_in;
      end
   end

   // ---------------- reconstruct stage ----------------
   assign s1_valid_in = (s1_valid_ff && !s1_go) || accept_pix;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_pix) begin
         s1_sb_ff     <= req_if.stream_byte;
         s1_filter_ff <= filter_ff;
         s1_pos_ff    <= pos_ff;
         s1_slot_ff   <= slot;
         s1_past_ff   <= past;
         s1_first_ff  <= first_row_ff;
         s1_eop_ff    <= eor || slot_last;
         s1_eor_ff    <= eor;
      end
   end

   // row above is read at acceptance, written back as the byte completes;
   // the same entry is read again only one full row later
   psu_line_buf #(
      .DEPTH (ROW_DEPTH),
      .AW    (AW)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_pos_ff),
      .wr_data (val),
      .rd_en   (accept_pix),
      .rd_addr (pos_ff),
      .rd_data (above)
   );

   always_comb begin
      pred_in.filter = s1_filter_ff;
      pred_in.a      = s1_past_ff ? left_ff[s1_slot_ff] : '0;
      pred_in.b      = s1_first_ff ? '0 : above;
      pred_in.c      = (s1_past_ff && !s1_first_ff) ? upl_ff[s1_slot_ff] : '0;
   end

   psu_predictor u_predictor (
      .pred_in (pred_in),
      .pred    (pred)
   );

   assign val = s1_sb_ff + pred;

   // histories restart at each filter byte; that clear wins over the last byte of the old row
   always_ff @(posedge clock) begin
      if (reset || (accept && await_eff)) begin
         for (int i = 0; i < MAX_BYTES_PER_PIXEL; i++) begin
            left_ff[i] <= '0;
            upl_ff[i]  <= '0;
         end
      end else if (s1_fire) begin
         left_ff[s1_slot_ff] <= val;
         upl_ff[s1_slot_ff]  <= pred_in.b;
      end
   end

   // ---------------- output register ----------------
   always_comb begin
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_byte_ff <= val;
         rsp_eop_ff  <= s1_eop_ff;
         rsp_eor_ff  <= s1_eor_ff;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.pixel_byte   = rsp_byte_ff;
   assign rsp_if.end_of_pixel = rsp_eop_ff;
   assign rsp_if.end_of_row   = rsp_eor_ff;

   // ---------------- assertions ----------------
   a_pixel_enters_stage: assert property (@(posedge clock) disable iff (reset)
      accept_pix |=> s1_valid_ff)
      else $error("accepted pixel byte did not reach reconstruct stage");

   a_row_end_ends_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_eor_ff || rsp_eop_ff))
      else $error("end of row without end of pixel");

   a_slot_in_pixel: assert property (@(posedge clock) disable iff (reset)
      BPPV_W'(slot) < bpp_ff)
      else $error("byte slot beyond pixel size");

   a_row_end_rearms: assert property (@(posedge clock) disable iff (reset)
      (accept_pix && eor) |=> (awaiting_ff && !first_row_ff && pos_ff == '0))
      else $error("row end did not rearm filter byte");

   a_stalled_result_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> (s1_valid_ff && $stable(s1_pos_ff)))
      else $error("stalled byte lost from reconstruct stage");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
   import psu_pkg::*;

   localparam int ROW_DEPTH    = MAX_ROW_PIXELS_DEF * MAX_BYTES_PER_PIXEL_DEF;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 6;
   localparam int PHASE_ITEMS  = 100;

   typedef struct packed {
      logic [BYTE_W-1:0] pixel_byte;
      logic              end_of_pixel;
      logic              end_of_row;
   } pixel_result;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   psu_req_if req_bus ();
   psu_rsp_if rsp_bus ();

   png_scanline_unfilter_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // unfilter state mirrored on the bench side
   logic [ROW_WIDTH_W-1:0] width_reg;
   logic [BPP_W-1:0]       bpp_reg;
   logic [BYTE_W-1:0]      row_above [ROW_DEPTH];
   logic [BYTE_W-1:0]      left_bytes [4];
   logic [BYTE_W-1:0]      upleft_bytes [4];
   psu_filter_type         cur_filter;
   logic [13:0]            cur_pos;
   logic                   want_filter;
   logic                   first_row;
   int                     written_len;

   pixel_result expected_pixels [$];
   int          error_count = 0;
   int          idle_phase  = 0;
   int          stall_cycles = 0;
   int          sent_items  = 0;

   function automatic int eff_width();
      int w;
      w = int'(width_reg);
      if (w < 1) w = 1;
      if (w > MAX_ROW_PIXELS_DEF) w = MAX_ROW_PIXELS_DEF;
      return w;
   endfunction

   function automatic int eff_bpp();
      int n;
      n = int'(bpp_reg);
      if (n < MIN_BPP) n = MIN_BPP;
      if (n > MAX_BYTES_PER_PIXEL_DEF) n = MAX_BYTES_PER_PIXEL_DEF;
      return n;
   endfunction

   function automatic logic [BYTE_W-1:0] filter_guess(input psu_filter_type f,
                                                      input logic [BYTE_W-1:0] a,
                                                      input logic [BYTE_W-1:0] b,
                                                      input logic [BYTE_W-1:0] c);
      int pa, pb, pc;
      case (f)
         FILT_SUB: return a;
         FILT_UP: return b;
         FILT_AVG: return BYTE_W'((int'(a) + int'(b)) >> 1);
         FILT_PAETH: begin
            pa = int'(b) - int'(c);
            pb = int'(a) - int'(c);
            pc = int'(a) + int'(b) - 2 * int'(c);
            if (pa < 0) pa = -pa;
            if (pb < 0) pb = -pb;
            if (pc < 0) pc = -pc;
            if (pa <= pb && pa <= pc) return a;
            if (pb <= pc) return b;
            return c;
         end
         default: return '0;
      endcase
   endfunction

   task automatic unfilter_item(input logic [BYTE_W-1:0] sb, input logic st);
      int                row_bytes, n, pos, slot;
      logic [BYTE_W-1:0] a, b, c, val;
      logic              eor, eop;
      if (st) begin
         first_row   = 1'b1;
         want_filter = 1'b1;
      end
      if (want_filter) begin
         cur_filter  = (sb > BYTE_W'(FILT_PAETH)) ? FILT_NONE : psu_filter_type'(sb[2:0]);
         cur_pos     = '0;
         want_filter = 1'b0;
         for (int i = 0; i < 4; i++) begin
            left_bytes[i]   = '0;
            upleft_bytes[i] = '0;
         end
         return;
      end
      n         = eff_bpp();
      row_bytes = eff_width() * n;
      pos       = int'(cur_pos) % ROW_DEPTH;
      slot      = (pos % n) & 3;
      a   = (pos >= n) ? left_bytes[slot] : '0;
      b   = first_row ? '0 : row_above[pos];
      c   = (!first_row && pos >= n) ? upleft_bytes[slot] : '0;
      val = sb + filter_guess(cur_filter, a, b, c);
      left_bytes[slot]   = val;
      upleft_bytes[slot] = b;
      row_above[pos]     = val;
      if (pos + 1 > written_len) written_len = pos + 1;
      eor = (pos + 1 >= row_bytes);
      eop = eor || ((pos % n) == n - 1);
      expected_pixels.push_back('{val, eop, eor});
      if (eor) begin
         cur_pos     = '0;
         want_filter = 1'b1;
         first_row   = 1'b0;
      end else begin
         cur_pos = 14'(pos + 1);
      end
   endtask

   function automatic logic sender_idles();
      case (idle_phase)
         0: return $urandom_range(0, 99) < 28;
         1: return $urandom_range(0, 99) < 50;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] rand_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hff;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] rand_filter();
      if ($urandom_range(0, 9) == 0) return BYTE_W'($urandom_range(5, 255));
      return BYTE_W'($urandom_range(0, 4));
   endfunction

   task automatic send_item(input logic [BYTE_W-1:0] sb, input logic st);
      logic start_bit;
      start_bit = st;
      // a pixel byte below the first row must find its byte above already written
      if (!start_bit && !want_filter && !first_row && int'(cur_pos) >= written_len)
         start_bit = 1'b1;
      while (sender_idles()) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.stream_byte <= sb;
      req_bus.image_start <= start_bit;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent_items++;
      unfilter_item(sb, start_bit);
   endtask

   task automatic send_row(input logic [BYTE_W-1:0] filter, input logic st, input int n);
      send_item(filter, st);
      repeat (n) send_item(rand_byte(), 1'b0);
   endtask

   task automatic wait_idle();
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      req_bus.valid <= 1'b0;
      wait_idle();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_ROW_WIDTH) width_reg = data[ROW_WIDTH_W-1:0];
      else bpp_reg = data[BPP_W-1:0];
   endtask

   // one pixel row at the reset geometry
   task automatic test_reset_defaults();
      send_item(BYTE_W'(FILT_NONE), 1'b1);
      send_item(8'h00, 1'b0);
      send_item(8'hff, 1'b0);
      send_item(8'h80, 1'b0);
   endtask

   task automatic test_each_filter();
      logic [BYTE_W-1:0] sub_bytes [6]   = '{8'hff, 8'h01, 8'h80, 8'hff, 8'h00, 8'h7f};
      logic [BYTE_W-1:0] paeth_bytes [6] = '{8'h10, 8'hf0, 8'h00, 8'hff, 8'h80, 8'h01};
      write_csr(CSR_ROW_WIDTH, CSR_DATA_W'(2));
      write_csr(CSR_BPP, CSR_DATA_W'(3));
      send_item(BYTE_W'(FILT_SUB), 1'b1);
      foreach (sub_bytes[i]) send_item(sub_bytes[i], 1'b0);
      send_item(BYTE_W'(FILT_PAETH), 1'b0);
      foreach (paeth_bytes[i]) send_item(paeth_bytes[i], 1'b0);
   endtask

   // unknown filter code, image restart mid-row, geometry change mid-row
   task automatic test_restart_and_resize();
      send_item(8'hff, 1'b0);
      send_item(8'h33, 1'b0);
      send_item(8'hcc, 1'b0);
      send_item(BYTE_W'(FILT_AVG), 1'b1);
      send_item(8'hfe, 1'b0);
      send_item(8'h02, 1'b0);
      send_item(8'hff, 1'b0);
      // row is now past the shorter length, so the next byte ends it
      write_csr(CSR_ROW_WIDTH, CSR_DATA_W'(1));
      send_item(8'h81, 1'b0);
      write_csr(CSR_BPP, CSR_DATA_W'(4));
      send_item(BYTE_W'(FILT_UP), 1'b0);
      send_item(8'h01, 1'b0);
      send_item(8'hff, 1'b0);
      send_item(8'h7f, 1'b0);
      send_item(8'h80, 1'b0);
   endtask

   task automatic test_random_stream(input int item_goal);
      int goal_end, rows, full, n, bsel, wsel;
      goal_end = sent_items + item_goal;
      while (sent_items < goal_end) begin
         if ($urandom_range(0, 2) == 0) begin
            wsel = $urandom_range(0, 19);
            if (wsel == 0) n = 0;
            else if (wsel >= 18) n = $urandom_range(9, 24);
            else n = $urandom_range(1, 8);
            write_csr(CSR_ROW_WIDTH, CSR_DATA_W'(n));
         end
         if ($urandom_range(0, 2) == 0) begin
            bsel = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(3, 4);
            write_csr(CSR_BPP, {10'($urandom_range(0, 1023)), 3'(bsel)});
         end
         if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 8);
            repeat (n) send_item(rand_byte(), $urandom_range(0, 7) == 0);
         end else begin
            rows = $urandom_range(1, 4);
            for (int r = 0; r < rows; r++) begin
               if (sent_items >= goal_end) break;
               full = eff_width() * eff_bpp();
               // broken row: cut short, the next image abandons it
               if ($urandom_range(0, 9) == 0) begin
                  send_row(rand_filter(), r == 0, $urandom_range(0, full - 1));
                  break;
               end
               send_row(rand_filter(), r == 0, full);
            end
         end
      end
   endtask

   // out of range width and pixel size clamp to the limits
   task automatic test_clamped_geometry();
      write_csr(CSR_ROW_WIDTH, '1);
      write_csr(CSR_BPP, CSR_DATA_W'(2));
      // a long row never ends early, the next image abandons it
      send_row(BYTE_W'(FILT_SUB), 1'b1, 24);
      write_csr(CSR_ROW_WIDTH, CSR_DATA_W'(2));
      write_csr(CSR_BPP, CSR_DATA_W'(7));
      send_row(BYTE_W'(FILT_AVG), 1'b1, 2 * MAX_BYTES_PER_PIXEL_DEF);
      send_row(BYTE_W'(FILT_PAETH), 1'b0, 2 * MAX_BYTES_PER_PIXEL_DEF);
   endtask

   always @(posedge clock) begin : result_check
      pixel_result got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.pixel_byte, rsp_bus.end_of_pixel, rsp_bus.end_of_row};
         if (expected_pixels.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected pixel item: byte %02h eop %b eor %b",
                        got.pixel_byte, got.end_of_pixel, got.end_of_row);
         end else begin
            want = expected_pixels.pop_front();
            if (got.pixel_byte !== want.pixel_byte || got.end_of_pixel !== want.end_of_pixel ||
                got.end_of_row !== want.end_of_row) begin
               error_count++;
               if (error_count <= 10)
                  $display("pixel mismatch: byte %02h/%02h eop %b/%b eor %b/%b (exp/got)",
                           want.pixel_byte, got.pixel_byte, want.end_of_pixel,
                           got.end_of_pixel, want.end_of_row, got.end_of_row);
            end
         end
      end
      case (idle_phase)
         0: rsp_bus.ready <= ($urandom_range(0, 99) >= 50);
         1: rsp_bus.ready <= ($urandom_range(0, 99) >= 28);
         default: rsp_bus.ready <= 1'b1;
      endcase
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      reset               <= 1'b1;
      csr_write           <= 1'b0;
      csr_index           <= CSR_ROW_WIDTH;
      csr_wdata           <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.stream_byte <= '0;
      req_bus.image_start <= 1'b0;
      width_reg   = ROW_WIDTH_W'(1);
      bpp_reg     = BPP_W'(MIN_BPP);
      cur_filter  = FILT_NONE;
      cur_pos     = '0;
      want_filter = 1'b1;
      first_row   = 1'b1;
      written_len = 0;
      for (int i = 0; i < 4; i++) begin
         left_bytes[i]   = '0;
         upleft_bytes[i] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_each_filter();
      test_restart_and_resize();
      test_random_stream(PHASE_ITEMS);
      idle_phase = 1;
      test_random_stream(PHASE_ITEMS);
      idle_phase = 2;
      test_random_stream(PHASE_ITEMS);
      test_clamped_geometry();

      req_bus.valid <= 1'b0;
      wait_idle();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
